>>> design/tkpjq_pkg.sv
// shared types, codes and key compare for the two-key priority job queue
package tkpjq_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned OCC_W   = 7;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_POPPED   = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_POP,
    ST_SCAN,
    ST_PLACE
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] size;
  } job_t;

  // true when job a must be served strictly after job b
  function automatic logic goes_after(input job_t a, input job_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio > b.prio);
    end else begin
      res = (a.size > b.size);
    end
    return res;
  endfunction

endpackage

>>> design/tkpjq_if.sv
// valid/ready channel interfaces for job requests and queue results
interface tkpjq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [tkpjq_pkg::FIELD_W-1:0]       job_id;
  logic [tkpjq_pkg::FIELD_W-1:0]       job_priority;
  logic [tkpjq_pkg::FIELD_W-1:0]       job_size;

  modport source (output valid, action, job_id, job_priority, job_size, input ready);
  modport sink   (input valid, action, job_id, job_priority, job_size, output ready);
endinterface

interface tkpjq_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [tkpjq_pkg::FIELD_W-1:0]       head_id;
  logic [tkpjq_pkg::FIELD_W-1:0]       head_priority;
  logic [tkpjq_pkg::FIELD_W-1:0]       head_size;
  logic [tkpjq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, status, head_id, head_priority, head_size, occupancy,
                  input ready);
  modport sink   (input valid, status, head_id, head_priority, head_size, occupancy,
                  output ready);
endinterface

>>> design/two_key_priority_job_queue.sv
// top level: stable two-key priority job queue kept as a sorted ring in one ram
// the result is registered in the output slot when the item finishes; an insert scans
//   from the tail down and moves at most DEPTH-1 entries, one entry moved per cycle
// one item at a time: a new request is taken only after the last result is loaded
// reset: synchronous active-low rst_n empties the queue; ram contents
//   are not cleared and no clearing pass runs, only entries below the count are read
module two_key_priority_job_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tkpjq_in_if.sink             in_chan,
  tkpjq_out_if.source          out_chan
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // ring storage: entries head .. tail-1 are sorted by (priority, size), stable
  tkpjq_pkg::job_t mem [DEPTH];
  tkpjq_pkg::job_t rdata_r;

  // ram port controls
  logic            re;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  tkpjq_pkg::job_t wdata;

  // control state
  tkpjq_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;

  // per-item working registers
  tkpjq_pkg::job_t    new_r, new_nxt;
  tkpjq_pkg::status_t stat_r, stat_nxt;
  logic [AW-1:0]      p_r, p_nxt;        // ring slot of the entry in rdata_r
  logic [CW-1:0]      k_r, k_nxt;        // entries still to look at, incl. p_r

  // output register
  logic               out_valid_r, out_valid_nxt;
  tkpjq_pkg::status_t out_stat_r;
  tkpjq_pkg::job_t    out_job_r;
  logic [tkpjq_pkg::OCC_W-1:0] out_occ_r;

  // finishing an item
  logic               fin;
  logic               fin_go;
  logic               can_emit;
  tkpjq_pkg::status_t emit_stat;
  tkpjq_pkg::job_t    emit_job;

  logic               in_fire;
  tkpjq_pkg::job_t    in_job;
  logic               is_full;
  logic               is_empty;
  logic               ga;
  logic [AW-1:0]      p_inc;
  logic [AW-1:0]      p_dec;
  logic [AW-1:0]      tail_dec;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    if (x == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = x + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    if (x == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = x - 1'b1;
    end
    return r;
  endfunction

  assign in_chan.ready = (state_r == tkpjq_pkg::ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_job        = '{id: in_chan.job_id, prio: in_chan.job_priority,
                           size: in_chan.job_size};

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign ga       = tkpjq_pkg::goes_after(rdata_r, new_r);
  assign p_inc    = ring_inc(p_r);
  assign p_dec    = ring_dec(p_r);
  assign tail_dec = ring_dec(tail_r);

  // output slot is free when empty or being drained this cycle
  assign can_emit = !out_valid_r || out_chan.ready;
  assign fin_go   = fin && can_emit;

  // sequencer: next state, ram port and result selection
  always_comb begin
    state_nxt = state_r;
    new_nxt   = new_r;
    stat_nxt  = stat_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    re        = 1'b0;
    raddr     = head_r;
    we        = 1'b0;
    waddr     = tail_r;
    wdata     = new_r;
    fin       = 1'b0;
    emit_stat = stat_r;
    emit_job  = '0;

    unique case (state_r)
      tkpjq_pkg::ST_IDLE: begin
        if (in_fire) begin
          new_nxt = in_job;
          if (in_chan.action == tkpjq_pkg::ACT_POP) begin
            if (is_empty) begin
              stat_nxt  = tkpjq_pkg::STAT_EMPTY;
              state_nxt = tkpjq_pkg::ST_FIN;
            end else begin
              // fetch the head entry
              re        = 1'b1;
              raddr     = head_r;
              stat_nxt  = tkpjq_pkg::STAT_POPPED;
              state_nxt = tkpjq_pkg::ST_POP;
            end
          end else begin
            if (is_full) begin
              stat_nxt  = tkpjq_pkg::STAT_FULL;
              state_nxt = tkpjq_pkg::ST_FIN;
            end else if (is_empty) begin
              // lone job goes straight into the tail slot
              we        = 1'b1;
              waddr     = tail_r;
              wdata     = in_job;
              stat_nxt  = tkpjq_pkg::STAT_INSERTED;
              state_nxt = tkpjq_pkg::ST_FIN;
            end else begin
              // start the backward scan at the last entry
              re        = 1'b1;
              raddr     = tail_dec;
              p_nxt     = tail_dec;
              k_nxt     = count_r;
              stat_nxt  = tkpjq_pkg::STAT_INSERTED;
              state_nxt = tkpjq_pkg::ST_SCAN;
            end
          end
        end
      end

      tkpjq_pkg::ST_FIN: begin
        fin = 1'b1;
        if (can_emit) begin
          state_nxt = tkpjq_pkg::ST_IDLE;
        end
      end

      tkpjq_pkg::ST_POP: begin
        // rdata_r holds the head entry until the result is taken
        fin       = 1'b1;
        emit_job  = rdata_r;
        if (can_emit) begin
          state_nxt = tkpjq_pkg::ST_IDLE;
        end
      end

      tkpjq_pkg::ST_SCAN: begin
        if (ga) begin
          // entry must follow the new job: move it up one slot
          we    = 1'b1;
          waddr = p_inc;
          wdata = rdata_r;
          if (k_r > CW'(1)) begin
            re    = 1'b1;
            raddr = p_dec;
            p_nxt = p_dec;
            k_nxt = k_r - 1'b1;
          end else begin
            state_nxt = tkpjq_pkg::ST_PLACE;
          end
        end else begin
          // equal or smaller key stays ahead: new job lands just behind it
          we    = 1'b1;
          waddr = p_inc;
          wdata = new_r;
          fin   = 1'b1;
          if (can_emit) begin
            state_nxt = tkpjq_pkg::ST_IDLE;
          end
        end
      end

      tkpjq_pkg::ST_PLACE: begin
        // every held job went after the new one: it becomes the head
        we    = 1'b1;
        waddr = p_r;
        wdata = new_r;
        fin   = 1'b1;
        if (can_emit) begin
          state_nxt = tkpjq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tkpjq_pkg::ST_IDLE;
      end
    endcase
  end

  // occupancy and ring pointers move once, when the result is loaded
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (fin_go) begin
      unique case (emit_stat)
        tkpjq_pkg::STAT_INSERTED: begin
          count_nxt = count_r + 1'b1;
          tail_nxt  = ring_inc(tail_r);
        end
        tkpjq_pkg::STAT_POPPED: begin
          count_nxt = count_r - 1'b1;
          head_nxt  = ring_inc(head_r);
        end
        tkpjq_pkg::STAT_EMPTY,
        tkpjq_pkg::STAT_FULL: begin
          count_nxt = count_r;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ram: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkpjq_pkg::ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    new_r  <= new_nxt;
    stat_r <= stat_nxt;
    p_r    <= p_nxt;
    k_r    <= k_nxt;
    if (fin_go) begin
      out_stat_r <= emit_stat;
      out_job_r  <= emit_job;
      out_occ_r  <= tkpjq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_stat_r;
  assign out_chan.head_id       = out_job_r.id;
  assign out_chan.head_priority = out_job_r.prio;
  assign out_chan.head_size     = out_job_r.size;
  assign out_chan.occupancy     = out_occ_r;

  // checks
  logic [AW:0] ring_sum;
  logic [AW:0] ring_wrap;
  assign ring_sum  = {1'b0, head_r} + (AW+1)'(count_r);
  assign ring_wrap = (ring_sum >= (AW+1)'(DEPTH)) ? ring_sum - (AW+1)'(DEPTH) : ring_sum;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(DEPTH)) || (tail_r == ring_wrap[AW-1:0]))
    else $error("tail pointer out of step with head and count");

  a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("ram read and write hit the same slot");

  a_pop_drops_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && (emit_stat == tkpjq_pkg::STAT_POPPED)) |=>
      (count_r == $past(count_r) - 1'b1))
    else $error("pop did not reduce the count");

  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkpjq_pkg::ST_SCAN) |-> (k_r != '0))
    else $error("scan running with no entries left");

endmodule
